FILE: hdl/rpn_stack_calculator_macros.svh
// Assertion macros shared by the stack calculator RTL.
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RSC_ASSERT_IMP(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RSC_ASSERT_NXT(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rsc_pkg.sv
// Shared types and constants of the RPN stack calculator.
`default_nettype none

package rsc_pkg;

  localparam int DATA_W          = 32;
  localparam int FUNC_W          = 4;
  localparam int DEPTH_W         = 9;
  localparam int STATUS_W        = 3;
  localparam int STACK_DEPTH_DEF = 256;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 4'd0,
    FN_ADD  = 4'd1,
    FN_SUB  = 4'd2,
    FN_MUL  = 4'd3,
    FN_DIV  = 4'd4,
    FN_POP  = 4'd5,
    FN_CLR  = 4'd6,
    FN_DUP  = 4'd7,
    FN_XCH  = 4'd8,
    FN_DISP = 4'd9
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_SAT   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_LOAD
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/rsc_intf.sv
// Command and result channel interfaces of the RPN stack calculator.
`default_nettype none

interface rsc_cmd_if;
  import rsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface rsc_res_if;
  import rsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic                     top_valid;
  logic [DEPTH_W-1:0]       depth;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output top_value, output top_valid, output depth,
                  output status, input ready);
  modport sink   (input valid, input top_value, input top_valid, input depth,
                  input status, output ready);
endinterface

`default_nettype wire

FILE: hdl/rsc_cell.sv
// One stack cell: holds an entry and trades it with its neighbors.
`default_nettype none

module rsc_cell (
  input  logic                   clk,
  input  rsc_pkg::cell_op_t      op,
  input  logic [rsc_pkg::DATA_W-1:0] shallower,
  input  logic [rsc_pkg::DATA_W-1:0] deeper,
  input  logic [rsc_pkg::DATA_W-1:0] load_value,
  output logic [rsc_pkg::DATA_W-1:0] value
);
  import rsc_pkg::*;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD: value <= value;
      CELL_PUSH: value <= shallower;
      CELL_POP:  value <= deeper;
      CELL_LOAD: value <= load_value;
      default:   value <= value;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/rsc_divider.sv
// Iterative Q16.16 divider, one quotient bit per cycle, saturating.
`default_nettype none

module rsc_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rsc_pkg::DATA_W-1:0]    dividend,
  input  logic [rsc_pkg::DATA_W-1:0]    divisor,
  output logic                          done,
  output logic [rsc_pkg::DATA_W-1:0]    quotient,
  output logic                          sat
);
  import rsc_pkg::*;

  localparam int HALF_W = DATA_W / 2;
  localparam int STEP_W = $clog2(DATA_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] ay;
  logic              neg;
  logic              ovf;

  logic [DATA_W-1:0] abs_x;
  logic [DATA_W-1:0] abs_y;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              ge;

  assign abs_x   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
  assign abs_y   = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = shifted - {1'b0, ay};
  assign ge      = shifted >= {1'b0, ay};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend is |x| shifted up by the fraction width. Its upper half seeds the
  // remainder; if that already reaches |y| the quotient cannot fit in 32 bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {{HALF_W{1'b0}}, abs_x[DATA_W-1:HALF_W]};
      quo <= {abs_x[HALF_W-1:0], {HALF_W{1'b0}}};
      ay  <= abs_y;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      ovf <= {{HALF_W{1'b0}}, abs_x[DATA_W-1:HALF_W]} >= abs_y;
    end else if (busy) begin
      rem <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], ge};
    end
  end

  // Magnitude quotient truncates toward zero; the sign is applied afterwards.
  always_comb begin
    sat      = 1'b0;
    quotient = quo;
    if (ovf) begin
      sat      = 1'b1;
      quotient = neg ? Q_MIN : Q_MAX;
    end else if (!neg) begin
      if (quo[DATA_W-1]) begin
        sat      = 1'b1;
        quotient = Q_MAX;
      end
    end else if (quo > Q_MIN) begin
      sat      = 1'b1;
      quotient = Q_MIN;
    end else begin
      quotient = ~quo + 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: control, arithmetic and the cell chain.
//
// Commands arrive on cmd (func, push_value) and each one yields exactly one
// result on res: the top entry (zero when empty), a top_valid flag, the
// depth after the command and a status code. Values are signed Q16.16.
// The stack is a chain of STACK_DEPTH cells with the top entry in cell 0;
// push and pop shift every cell toward its neighbor at once.
// cmd.ready is high only while the controller is idle, so one command is
// in flight at a time. Path from cmd transfer to res valid, via S_DONE:
//   push, pop, clear, dup, exchange, display, add, sub: straight to S_DONE;
//   multiply with two operands: S_MUL (registered 32x32 product, then round and clip);
//   divide with two operands and a nonzero top: S_DIV, for the one-bit-per-cycle divider (32 steps).
// A new command is taken as soon as the previous result sits in the output
// register, even if res is stalled; the one after that waits until res
// transfers. The output register holds its contents while res.ready is low.
// Reset empties the stack (count zero) and drops any pending result; the
// cell contents are left as they were and are never read before written.
`default_nettype none
`include "rpn_stack_calculator_macros.svh"

module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  rsc_cmd_if.sink  cmd,
  rsc_res_if.source res
);
  import rsc_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] COUNT_ONE  = CW'(1);

  state_t  state, state_next;
  status_t st_reg, st_next;
  logic [CW-1:0] count, count_next;

  logic [DATA_W-1:0] vals [STACK_DEPTH];
  cell_op_t          shift_op;
  logic              load0;
  logic              load1;
  logic [DATA_W-1:0] load0_val;
  logic [DATA_W-1:0] push_src;

  func_t func;
  logic  empty, single, full;
  logic  out_load;

  logic [DATA_W:0]   addsub;
  logic              addsub_sat;
  logic [DATA_W-1:0] addsub_res;
  logic [DATA_W-1:0] divz_res;

  logic                       mul_start;
  logic signed [2*DATA_W-1:0] prod;
  logic [2*DATA_W-1:0]        prod_rnd;
  logic [3*DATA_W/2-1:0]      mul_r;
  logic                       mul_sat;
  logic [DATA_W-1:0]          mul_res;

  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_q;
  logic              div_sat;

  logic [31:0] count_ext;

  assign func   = func_t'(cmd.func);
  assign empty  = count == '0;
  assign single = count == COUNT_ONE;
  assign full   = count == COUNT_FULL;

  // x is the entry below the top, y is the top.
  assign addsub = (func == FN_SUB)
                ? ({vals[1][DATA_W-1], vals[1]} - {vals[0][DATA_W-1], vals[0]})
                : ({vals[1][DATA_W-1], vals[1]} + {vals[0][DATA_W-1], vals[0]});
  assign addsub_sat = addsub[DATA_W] != addsub[DATA_W-1];
  assign addsub_res = addsub_sat ? (addsub[DATA_W] ? Q_MIN : Q_MAX) : addsub[DATA_W-1:0];

  assign divz_res = vals[1][DATA_W-1] ? Q_MIN : ((vals[1] == '0) ? '0 : Q_MAX);

  always_ff @(posedge clk) begin
    if (mul_start) begin
      prod <= $signed(vals[1]) * $signed(vals[0]);
    end
  end

  // Round to nearest with ties upward: add half an LSB, then an arithmetic
  // shift by the fraction width.
  assign prod_rnd = prod + (2*DATA_W)'(32'h0000_8000);
  assign mul_r    = prod_rnd[2*DATA_W-1:DATA_W/2];
  assign mul_sat  = !((&mul_r[3*DATA_W/2-1:DATA_W-1]) || !(|mul_r[3*DATA_W/2-1:DATA_W-1]));
  assign mul_res  = mul_sat ? (mul_r[3*DATA_W/2-1] ? Q_MIN : Q_MAX) : mul_r[DATA_W-1:0];

  rsc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (vals[1]),
    .divisor  (vals[0]),
    .done     (div_done),
    .quotient (div_q),
    .sat      (div_sat)
  );

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      cell_op_t          op;
      logic [DATA_W-1:0] shallower;
      logic [DATA_W-1:0] deeper;
      logic [DATA_W-1:0] load_value;

      if (gi == 0) begin : g_top
        assign op         = load0 ? CELL_LOAD : shift_op;
        assign shallower  = push_src;
        assign load_value = load0_val;
      end else if (gi == 1) begin : g_second
        assign op         = load1 ? CELL_LOAD : shift_op;
        assign shallower  = vals[gi-1];
        assign load_value = vals[0];
      end else begin : g_rest
        assign op         = shift_op;
        assign shallower  = vals[gi-1];
        assign load_value = vals[gi];
      end

      if (gi == STACK_DEPTH - 1) begin : g_last
        assign deeper = vals[gi];
      end else begin : g_inner
        assign deeper = vals[gi+1];
      end

      rsc_cell u_cell (
        .clk        (clk),
        .op         (op),
        .shallower  (shallower),
        .deeper     (deeper),
        .load_value (load_value),
        .value      (vals[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      st_reg <= ST_OK;
    end else begin
      state  <= state_next;
      count  <= count_next;
      st_reg <= st_next;
    end
  end

  assign cmd.ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    count_next = count;
    st_next    = st_reg;
    shift_op   = CELL_HOLD;
    load0      = 1'b0;
    load1      = 1'b0;
    load0_val  = addsub_res;
    push_src   = cmd.push_value;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_DONE;
          st_next    = ST_OK;
          unique case (func) inside
            FN_PUSH: begin
              if (full) begin
                st_next = ST_OVER;
              end else begin
                shift_op   = CELL_PUSH;
                count_next = count + 1'b1;
              end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_XCH: begin
              if (empty) begin
                st_next = ST_UNDER;
              end else if (single) begin
                // A lone operand is consumed and nothing is pushed.
                count_next = '0;
                st_next    = ST_UNDER;
              end else begin
                case (func) inside
                  FN_ADD, FN_SUB: begin
                    load0      = 1'b1;
                    shift_op   = CELL_POP;
                    count_next = count - 1'b1;
                    st_next    = addsub_sat ? ST_SAT : ST_OK;
                  end
                  FN_MUL: begin
                    mul_start  = 1'b1;
                    state_next = S_MUL;
                  end
                  FN_DIV: begin
                    if (vals[0] == '0) begin
                      load0      = 1'b1;
                      load0_val  = divz_res;
                      shift_op   = CELL_POP;
                      count_next = count - 1'b1;
                      st_next    = ST_DIVZ;
                    end else begin
                      div_start  = 1'b1;
                      state_next = S_DIV;
                    end
                  end
                  default: begin
                    load0     = 1'b1;
                    load1     = 1'b1;
                    load0_val = vals[1];
                  end
                endcase
              end
            end
            FN_POP: begin
              if (empty) begin
                st_next = ST_UNDER;
              end else begin
                shift_op   = CELL_POP;
                count_next = count - 1'b1;
              end
            end
            FN_CLR: begin
              count_next = '0;
            end
            FN_DUP: begin
              if (empty) begin
                st_next = ST_UNDER;
              end else if (full) begin
                st_next = ST_OVER;
              end else begin
                push_src   = vals[0];
                shift_op   = CELL_PUSH;
                count_next = count + 1'b1;
              end
            end
            FN_DISP: begin
              if (empty) begin
                st_next = ST_UNDER;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL: begin
        load0      = 1'b1;
        load0_val  = mul_res;
        shift_op   = CELL_POP;
        count_next = count - 1'b1;
        st_next    = mul_sat ? ST_SAT : ST_OK;
        state_next = S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          load0      = 1'b1;
          load0_val  = div_q;
          shift_op   = CELL_POP;
          count_next = count - 1'b1;
          st_next    = div_sat ? ST_SAT : ST_OK;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!res.valid || res.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign count_ext = 32'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.top_value <= empty ? '0 : vals[0];
      res.top_valid <= !empty;
      res.depth     <= count_ext[DEPTH_W-1:0];
      res.status    <= st_reg;
    end
  end

  `RSC_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= COUNT_FULL, "stack count beyond depth")
  `RSC_ASSERT_NXT(a_one_in_flight, clk, rst, cmd.valid && cmd.ready, !cmd.ready, "second command taken")
  `RSC_ASSERT_IMP(a_div_done_state, clk, rst, div_done, state == S_DIV, "divider finished unexpectedly")

endmodule

`default_nettype wire
